FILE: hw/rtl/sws_pkg.sv
package sws_pkg;

    // voice setup
    localparam int NUM_PITCHES = 8;
    localparam int MAX_VOICES  = 8;
    localparam int VOICE_CAP   = (MAX_VOICES < NUM_PITCHES) ? MAX_VOICES : NUM_PITCHES;
    localparam int SAMPLE_RATE = 22050;
    localparam int PITCH_ROWS  = 108;
    localparam int INC_ROWS    = 128;

    // mix scaling
    localparam int GAIN_ONE     = 16384;
    localparam int GAIN_SHIFT   = 14;
    localparam int MASTER_SCALE = 13107;

    // datapath widths
    localparam int MUL_W     = 32;
    localparam int DEN_W     = 16;
    localparam int DIV_STEPS = 14;
    localparam int DVD_W     = DEN_W + DIV_STEPS;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    // register reset values
    localparam logic [15:0] SPS_RESET     = 16'd5512;
    localparam logic [15:0] ATTACK_RESET  = 16'd441;
    localparam logic [15:0] RELEASE_RESET = 16'd661;

    // register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SPS     = 2'd0;
    localparam cfg_idx_t CFG_ATTACK  = 2'd1;
    localparam cfg_idx_t CFG_RELEASE = 2'd2;

    typedef logic [6:0] pitch_t;
    typedef logic [3:0] count_t;

    typedef struct packed {
        logic   step_start;
        count_t voice_count;
        pitch_t pitch_0;
        pitch_t pitch_1;
        pitch_t pitch_2;
        pitch_t pitch_3;
        pitch_t pitch_4;
        pitch_t pitch_5;
        pitch_t pitch_6;
        pitch_t pitch_7;
    } in_word_t;

    typedef struct packed {
        logic signed [14:0] pcm_sample;
        logic               step_end;
    } out_word_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] divisor;
        logic [DVD_W-1:0] dividend;
    } div_req_t;

    // octave-4 note frequencies, Q16.16 Hz
    function automatic logic [31:0] base_freq_q16(input int semi);
        case (semi)
            0:       return 32'd17146184;
            1:       return 32'd18165268;
            2:       return 32'd19245302;
            3:       return 32'd20390216;
            4:       return 32'd21602632;
            5:       return 32'd22887137;
            6:       return 32'd24247665;
            7:       return 32'd25690112;
            8:       return 32'd27217101;
            9:       return 32'd28835840;
            10:      return 32'd30550262;
            default: return 32'd32366920;
        endcase
    endfunction

    // round(1.8 / n^0.8 * 16384)
    function automatic logic [14:0] gain_q14(input count_t n);
        case (n)
            4'd1:    return 15'd29491;
            4'd2:    return 15'd16938;
            4'd3:    return 15'd12246;
            4'd4:    return 15'd9728;
            4'd5:    return 15'd8138;
            4'd6:    return 15'd7033;
            4'd7:    return 15'd6217;
            4'd8:    return 15'd5588;
            4'd9:    return 15'd5085;
            4'd10:   return 15'd4674;
            4'd11:   return 15'd4331;
            4'd12:   return 15'd4040;
            4'd13:   return 15'd3789;
            4'd14:   return 15'd3571;
            4'd15:   return 15'd3379;
            default: return 15'd0;
        endcase
    endfunction

    // phase increment of a grid row; only evaluated at elaboration
    function automatic logic [31:0] calc_inc(input int row);
        logic [63:0] num;
        int          semi;
        int          shamt;
        semi  = 11 - (row % 12);
        shamt = 20 - (row / 12);
        num   = 64'(base_freq_q16(semi)) << shamt;
        return 32'((num + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
    endfunction

endpackage

FILE: hw/rtl/sws_mul.sv
module sws_mul
    import sws_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [MUL_W-1:0]     op_a,
    input  logic [MUL_W-1:0]     op_b,
    output logic [2*MUL_W-1:0]   prod
);

    logic [2*MUL_W-1:0] prod_reg;
    logic [2*MUL_W-1:0] prod_next;

    assign prod_next = (2*MUL_W)'(op_a) * (2*MUL_W)'(op_b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

FILE: hw/rtl/sws_div.sv
module sws_div
    import sws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 busy,
    output logic [DIV_STEPS-1:0] quotient
);

    // restoring divide; dividend's upper part must already be below divisor
    logic [DEN_W:0]       rem_reg, rem_next;
    logic [DIV_STEPS-1:0] quo_reg, quo_next;
    logic [DCNT_W-1:0]    cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DEN_W:0]       rem_sh;
    logic [DEN_W:0]       rem_sub;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[DEN_W-1:0], quo_reg[DIV_STEPS-1]};
        rem_sub   = rem_sh - {1'b0, req.divisor};
        if (req.start)
        begin
            rem_next  = {1'b0, req.dividend[DVD_W-1:DIV_STEPS]};
            quo_next  = req.dividend[DIV_STEPS-1:0];
            cnt_next  = DCNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, req.divisor})
            begin
                rem_next = rem_sub;
                quo_next = {quo_reg[DIV_STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/square_wave_step_synth.sv
// Square-wave step synthesizer: one mono PCM sample per input word.
// Input channel (in_valid/in_ready/in_word): one word per sample tick. With
// step_start set the word latches a new voice set (voice_count, pitch_0..7).
// Output channel (out_valid/out_ready/out_word): one word per input word, in
// order: pcm_sample (15-bit signed) and step_end on the last sample of a step.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// index 0 samples_per_step, 1 attack_samples, 2 release_samples. Write only
// while the block is idle.
// The datapath uses one shared 32x32 multiplier (one phase product per voice,
// then gain and envelope scaling) and a 14-step shift/subtract divider for
// the envelope ratio; a silent sample skips both. in_ready is low for the
// whole computation, so a new word is taken only after the previous result
// has gone into the output register.
// A finished word sits in the output register; the next input word is taken
// while it waits. If the receiver stalls, the next result is held inside until
// the output register frees up, and in_ready stays low meanwhile.
// Reset: registers return to their defaults, no voices held, sample and step
// counters cleared, output channel empty.
module square_wave_step_synth
    import sws_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_idx_t   cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PHASE = 9'b000000010,
        ST_PACC  = 9'b000000100,
        ST_GAIN  = 9'b000001000,
        ST_CLIP  = 9'b000010000,
        ST_MNUM  = 9'b000100000,
        ST_MSC   = 9'b001000000,
        ST_DIVS  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    localparam int K_W = $clog2(NUM_PITCHES);

    // phase increment per grid row, built at elaboration
    logic [31:0] inc_tab [INC_ROWS];
    for (genvar r = 0; r < INC_ROWS; r++)
    begin : g_inc
        localparam logic [31:0] INC = calc_inc(r);
        assign inc_tab[r] = INC;
    end

    state_t             state_reg, state_next;
    logic [15:0]        sps_reg, sps_next;
    logic [15:0]        att_reg, att_next;
    logic [15:0]        rel_reg, rel_next;
    pitch_t             pitch_reg [NUM_PITCHES];
    pitch_t             pitch_next [NUM_PITCHES];
    count_t             count_reg, count_next;
    logic [15:0]        sis_reg, sis_next;
    logic [31:0]        gsi_reg, gsi_next;
    logic [31:0]        gsi_work_reg, gsi_work_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic signed [4:0]  sum_reg, sum_next;
    logic [14:0]        vmag_reg, vmag_next;
    logic [15:0]        num_reg, num_next;
    logic [15:0]        den_reg, den_next;
    logic               end_reg, end_next;
    logic signed [14:0] res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    // shared multiplier
    logic               mul_en;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] prod;

    // divider
    div_req_t             div_req;
    logic                 div_busy;
    logic [DIV_STEPS-1:0] quo;

    // accept-time decode
    logic        accept;
    pitch_t      pitch_in [NUM_PITCHES];
    count_t      cnt_sat;
    count_t      cur_count;
    logic [15:0] cur_i;
    logic [15:0] sps_eff;
    logic        active;
    logic        attack_on;
    logic        rel_on;
    logic [3:0]  sum_mag;

    sws_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    sws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (quo)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign pitch_in[0] = in_word.pitch_0;
    assign pitch_in[1] = in_word.pitch_1;
    assign pitch_in[2] = in_word.pitch_2;
    assign pitch_in[3] = in_word.pitch_3;
    assign pitch_in[4] = in_word.pitch_4;
    assign pitch_in[5] = in_word.pitch_5;
    assign pitch_in[6] = in_word.pitch_6;
    assign pitch_in[7] = in_word.pitch_7;

    always_comb
    begin
        cnt_sat   = (in_word.voice_count > count_t'(VOICE_CAP)) ?
                    count_t'(VOICE_CAP) : in_word.voice_count;
        cur_count = in_word.step_start ? cnt_sat : count_reg;
        cur_i     = in_word.step_start ? 16'd0 : sis_reg;
        sps_eff   = (sps_reg == 16'd0) ? 16'd1 : sps_reg;
        active    = (cur_count != 4'd0) && (cur_i < sps_eff);
        attack_on = (att_reg != 16'd0) && (cur_i < att_reg);
        // release ramp: i + release >= step length, 17-bit to avoid wrap
        rel_on    = (rel_reg != 16'd0) &&
                    (({1'b0, cur_i} + {1'b0, rel_reg}) >= {1'b0, sps_eff});
        sum_mag   = sum_reg[4] ? 4'(-sum_reg) : 4'(sum_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        sps_next       = sps_reg;
        att_next       = att_reg;
        rel_next       = rel_reg;
        pitch_next     = pitch_reg;
        count_next     = count_reg;
        sis_next       = sis_reg;
        gsi_next       = gsi_reg;
        gsi_work_next  = gsi_work_reg;
        k_next         = k_reg;
        sum_next       = sum_reg;
        vmag_next      = vmag_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        end_next       = end_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_req.start    = 1'b0;
        div_req.divisor  = den_reg;
        div_req.dividend = prod[GAIN_SHIFT+DVD_W-1:GAIN_SHIFT];

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SPS:     sps_next = cfg_data;
                CFG_ATTACK:  att_next = cfg_data;
                CFG_RELEASE: rel_next = cfg_data;
                default:     ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.step_start)
                    begin
                        count_next = cnt_sat;
                        for (int p = 0; p < NUM_PITCHES; p++)
                        begin
                            pitch_next[p] = (pitch_in[p] > pitch_t'(PITCH_ROWS - 1)) ?
                                            pitch_t'(PITCH_ROWS - 1) : pitch_in[p];
                        end
                    end
                    sis_next      = (cur_i != 16'hFFFF) ? cur_i + 16'd1 : cur_i;
                    gsi_next      = gsi_reg + 32'd1;
                    gsi_work_next = gsi_reg;
                    end_next      = (({1'b0, cur_i} + 17'd1) == {1'b0, sps_eff});
                    k_next        = '0;
                    sum_next      = '0;
                    if (attack_on)
                    begin
                        num_next = cur_i;
                        den_next = att_reg;
                    end
                    else if (rel_on)
                    begin
                        num_next = sps_eff - cur_i;
                        den_next = rel_reg;
                    end
                    else
                    begin
                        num_next = 16'd1;
                        den_next = 16'd1;
                    end
                    if (active)
                    begin
                        state_next = ST_PHASE;
                    end
                    else
                    begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_PHASE:
            begin
                // phase = index * increment mod 2^32; square wave from the MSB
                mul_en     = 1'b1;
                mul_a      = gsi_work_reg;
                mul_b      = inc_tab[pitch_reg[k_reg]];
                state_next = ST_PACC;
            end
            ST_PACC:
            begin
                sum_next = prod[31] ? sum_reg - 5'sd1 : sum_reg + 5'sd1;
                k_next   = k_reg + 1'b1;
                if (({1'b0, k_reg} + count_t'(1)) == count_reg)
                begin
                    state_next = ST_GAIN;
                end
                else
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_GAIN:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(sum_mag);
                mul_b      = MUL_W'(gain_q14(count_reg));
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                vmag_next  = (prod > (2*MUL_W)'(GAIN_ONE)) ? 15'(GAIN_ONE) : prod[14:0];
                state_next = ST_MNUM;
            end
            ST_MNUM:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(vmag_reg);
                mul_b      = MUL_W'(num_reg);
                state_next = ST_MSC;
            end
            ST_MSC:
            begin
                mul_en     = 1'b1;
                mul_a      = prod[MUL_W-1:0];
                mul_b      = MUL_W'(MASTER_SCALE);
                state_next = ST_DIVS;
                k_next     = '0;
            end
            ST_DIVS:
            begin
                // first pass starts the divider, then wait for it to finish
                if (k_reg == '0)
                begin
                    div_req.start = 1'b1;
                    k_next        = K_W'(1);
                end
                else if (!div_busy)
                begin
                    res_next   = sum_reg[4] ? 15'sd0 - $signed({1'b0, quo}) :
                                              $signed({1'b0, quo});
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_word_next.pcm_sample = res_reg;
                    out_word_next.step_end   = end_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sps_reg       <= SPS_RESET;
            att_reg       <= ATTACK_RESET;
            rel_reg       <= RELEASE_RESET;
            count_reg     <= '0;
            sis_reg       <= '0;
            gsi_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sps_reg       <= sps_next;
            att_reg       <= att_next;
            rel_reg       <= rel_next;
            count_reg     <= count_next;
            sis_reg       <= sis_next;
            gsi_reg       <= gsi_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pitch_reg    <= pitch_next;
        gsi_work_reg <= gsi_work_next;
        k_reg        <= k_next;
        sum_reg      <= sum_next;
        vmag_reg     <= vmag_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        end_reg      <= end_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: hw/rtl/sws_chk.sv
module sws_chk
    import sws_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word changed under stall");

    // scaled sample never leaves the master range
    a_pcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.pcm_sample >= -15'sd13107) &&
                      (out_word.pcm_sample <= 15'sd13107))
        else $error("pcm sample out of range");

    // one word at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken twice in a row");

endmodule

bind square_wave_step_synth sws_chk u_sws_chk (.*);
